/* design/line_edit_ring_buffer_macros.svh */
// Assertion macros shared by the line edit ring buffer.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LINE_EDIT_RING_BUFFER_MACROS_SVH
`define LINE_EDIT_RING_BUFFER_MACROS_SVH

// Same-cycle implication.
`define LER_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line_edit_ring_buffer: assertion failed");

// Next-cycle implication.
`define LER_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line_edit_ring_buffer: assertion failed");

`endif

/* design/ler_pkg.sv */
package ler_pkg;

  localparam int unsigned NUM_LINES_DEF = 8;
  localparam int unsigned LINE_LEN_DEF  = 128;
  localparam int unsigned MAX_READ_DEF  = 64;

  localparam logic [7:0] KEY_NEWLINE   = 8'd10;
  localparam logic [7:0] KEY_BACKSPACE = 8'd8;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       status;
    logic       line_done;
    logic       last;
  } result_t;

endpackage

/* design/ler_ram.sv */
module ler_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ler_out_fifo.sv */
module ler_out_fifo import ler_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  result_t              push_data_i,
  output logic [OUT_CNT_W-1:0] count_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output result_t              out_data_o
);

  result_t                mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wptr_q, wptr_d;
  logic [OUT_PTR_W-1:0]   rptr_q, rptr_d;
  logic [OUT_CNT_W-1:0]   count_q, count_d;
  logic                   pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  assign count_o     = count_q;
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* design/line_edit_ring_buffer.sv */
// A keystroke transaction is absorbed without stalling the input and produces no result.
// A read transaction stalls the input while it is served: first the line length is fetched,
// then one line memory read per cycle is issued while the output queue has room.
// Each result is registered with its read data, then leaves through a two-entry output queue.
// Reset clears the ready flags, slot pointers, column and offset at once; the line memory
// needs no clearing pass.
`include "line_edit_ring_buffer_macros.svh"

module line_edit_ring_buffer import ler_pkg::*; #(
  parameter int unsigned NUM_LINES = NUM_LINES_DEF,
  parameter int unsigned LINE_LEN  = LINE_LEN_DEF,
  parameter int unsigned MAX_READ  = MAX_READ_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] key_char_i,
  input  logic [6:0] read_len_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       status_o,
  output logic       line_done_o,
  output logic       last_o
);

  localparam int unsigned SLOT_W      = $clog2(NUM_LINES);
  localparam int unsigned LEN_W       = $clog2(LINE_LEN + 1);
  localparam int unsigned COL_W       = $clog2(LINE_LEN);
  localparam int unsigned RD_W        = $clog2(MAX_READ + 1);
  localparam int unsigned CMP_W       = (LEN_W > 7) ? LEN_W : 7;
  localparam int unsigned STORE_DEPTH = NUM_LINES * (2 ** COL_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_META = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [SLOT_W-1:0]    ws_q, ws_d;
  logic [SLOT_W-1:0]    rs_q, rs_d;
  logic [LEN_W-1:0]     wcol_q, wcol_d;
  logic [LEN_W-1:0]     offset_q, offset_d;
  logic [NUM_LINES-1:0] ready_q, ready_d;
  logic [RD_W-1:0]      len_q, len_d;
  logic [LEN_W-1:0]     col_q, col_d;
  logic [RD_W-1:0]      cnt_q, cnt_d;
  logic                 done_q, done_d;

  logic rd_vld_q, rd_vld_d;
  logic rd_byte_q, rd_byte_d;
  logic rd_stat_q, rd_stat_d;
  logic rd_done_q, rd_done_d;
  logic rd_last_q, rd_last_d;

  logic                     st_we, st_re;
  logic [SLOT_W+COL_W-1:0]  st_waddr, st_raddr;
  logic [7:0]               st_rdata;
  logic                     ln_we, ln_re;
  logic [LEN_W-1:0]         ln_rdata;

  logic                 in_acc;
  logic [RD_W-1:0]      len_clamp;
  logic [LEN_W-1:0]     remain;
  logic [CMP_W-1:0]     rem_ext, len_ext, meta_n_ext;
  logic                 meta_done;
  logic [RD_W-1:0]      meta_n;
  logic                 meta_ready;

  result_t              push_data;
  result_t              out_data;
  logic [OUT_CNT_W-1:0] fifo_cnt;
  logic                 fifo_pop;
  logic [OUT_CNT_W:0]   occ, lim;
  logic                 issue_ok;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);

  assign len_clamp = (read_len_i > 7'(MAX_READ)) ? RD_W'(MAX_READ) : read_len_i[RD_W-1:0];

  assign remain     = (ln_rdata > offset_q) ? ln_rdata - offset_q : '0;
  assign rem_ext    = CMP_W'(remain);
  assign len_ext    = CMP_W'(len_q);
  assign meta_done  = (rem_ext <= len_ext);
  assign meta_n_ext = meta_done ? rem_ext : len_ext;
  assign meta_n     = meta_n_ext[RD_W-1:0];
  assign meta_ready = ready_q[rs_q];

  assign fifo_pop = out_valid_o && !out_stall_i;
  assign occ      = (OUT_CNT_W + 1)'(fifo_cnt) + (OUT_CNT_W + 1)'(rd_vld_q);
  assign lim      = (OUT_CNT_W + 1)'(OUT_DEPTH - 1) + (OUT_CNT_W + 1)'(fifo_pop);
  assign issue_ok = (occ <= lim);

  assign st_waddr = {ws_q, wcol_q[COL_W-1:0]};
  assign st_raddr = {rs_q, col_q[COL_W-1:0]};

  always_comb begin
    state_d   = state_q;
    ws_d      = ws_q;
    rs_d      = rs_q;
    wcol_d    = wcol_q;
    offset_d  = offset_q;
    ready_d   = ready_q;
    len_d     = len_q;
    col_d     = col_q;
    cnt_d     = cnt_q;
    done_d    = done_q;
    rd_vld_d  = 1'b0;
    rd_byte_d = rd_byte_q;
    rd_stat_d = rd_stat_q;
    rd_done_d = rd_done_q;
    rd_last_d = rd_last_q;
    st_we     = 1'b0;
    st_re     = 1'b0;
    ln_we     = 1'b0;
    ln_re     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (req_type_i == REQ_READ)) begin
          len_d   = len_clamp;
          ln_re   = 1'b1;
          state_d = S_META;
        end else if (in_acc && !ready_q[ws_q]) begin
          unique case (key_char_i)
            KEY_NEWLINE: begin
              ln_we       = 1'b1;
              ready_d[ws_q] = 1'b1;
              ws_d        = (ws_q == SLOT_W'(NUM_LINES - 1)) ? '0 : ws_q + 1'b1;
              wcol_d      = '0;
            end
            KEY_BACKSPACE: begin
              if (wcol_q != '0) begin
                wcol_d = wcol_q - 1'b1;
              end
            end
            default: begin
              if (wcol_q < LEN_W'(LINE_LEN)) begin
                st_we  = 1'b1;
                wcol_d = wcol_q + 1'b1;
              end
            end
          endcase
        end
      end
      S_META: begin
        if (!meta_ready || (meta_n == '0)) begin
          if (issue_ok) begin
            rd_vld_d  = 1'b1;
            rd_byte_d = 1'b0;
            rd_stat_d = !meta_ready;
            rd_done_d = meta_ready && meta_done;
            rd_last_d = 1'b1;
            state_d   = S_IDLE;
            if (meta_ready && meta_done) begin
              ready_d[rs_q] = 1'b0;
              offset_d      = '0;
              rs_d          = (rs_q == SLOT_W'(NUM_LINES - 1)) ? '0 : rs_q + 1'b1;
            end
          end
        end else begin
          col_d   = offset_q;
          cnt_d   = meta_n;
          done_d  = meta_done;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (issue_ok) begin
          st_re     = 1'b1;
          rd_vld_d  = 1'b1;
          rd_byte_d = 1'b1;
          rd_stat_d = 1'b0;
          rd_done_d = done_q;
          rd_last_d = (cnt_q == RD_W'(1));
          col_d     = col_q + 1'b1;
          cnt_d     = cnt_q - 1'b1;
          if (cnt_q == RD_W'(1)) begin
            state_d = S_IDLE;
            if (done_q) begin
              ready_d[rs_q] = 1'b0;
              offset_d      = '0;
              rs_d          = (rs_q == SLOT_W'(NUM_LINES - 1)) ? '0 : rs_q + 1'b1;
            end else begin
              offset_d = col_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ws_q     <= '0;
      rs_q     <= '0;
      wcol_q   <= '0;
      offset_q <= '0;
      ready_q  <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ws_q     <= ws_d;
      rs_q     <= rs_d;
      wcol_q   <= wcol_d;
      offset_q <= offset_d;
      ready_q  <= ready_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    col_q     <= col_d;
    done_q    <= done_d;
    rd_byte_q <= rd_byte_d;
    rd_stat_q <= rd_stat_d;
    rd_done_q <= rd_done_d;
    rd_last_q <= rd_last_d;
  end

  ler_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (key_char_i),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  ler_ram #(
    .WIDTH (LEN_W),
    .DEPTH (NUM_LINES)
  ) u_line_length (
    .clk_i   (clk_i),
    .we_i    (ln_we),
    .waddr_i (ws_q),
    .wdata_i (wcol_q),
    .re_i    (ln_re),
    .raddr_i (rs_q),
    .rdata_o (ln_rdata)
  );

  always_comb begin
    push_data.data_byte  = rd_byte_q ? st_rdata : 8'd0;
    push_data.byte_valid = rd_byte_q;
    push_data.status     = rd_stat_q;
    push_data.line_done  = rd_done_q;
    push_data.last       = rd_last_q;
  end

  ler_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rd_vld_q),
    .push_data_i (push_data),
    .count_o     (fifo_cnt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign data_byte_o  = out_data.data_byte;
  assign byte_valid_o = out_data.byte_valid;
  assign status_o     = out_data.status;
  assign line_done_o  = out_data.line_done;
  assign last_o       = out_data.last;

  `LER_ASSERT_IMP(a_queue_room, rd_vld_q, fifo_cnt <= OUT_CNT_W'(OUT_DEPTH - 1))
  `LER_ASSERT_IMP(a_emit_count, state_q == S_EMIT, cnt_q != '0)
  `LER_ASSERT_NXT(a_emit_end, (state_q == S_EMIT) && issue_ok && (cnt_q == RD_W'(1)), state_q == S_IDLE)
  `LER_ASSERT_IMP(a_status_alone, out_valid_o && status_o, !byte_valid_o && last_o && !line_done_o)

endmodule

/* dv/tb_line_edit_ring_buffer.sv */
`timescale 1ns / 100ps

module tb_line_edit_ring_buffer;
  import ler_pkg::*;

  localparam int unsigned NL = NUM_LINES_DEF;
  localparam int unsigned LL = LINE_LEN_DEF;
  localparam int unsigned MR = MAX_READ_DEF;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 150;

  typedef struct {
    logic        req;
    logic [7:0]  ch;
    logic [6:0]  len;
    int unsigned gap;
  } kbd_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       req_type_i = REQ_KEY;
  logic [7:0] key_char_i = 8'd0;
  logic [6:0] read_len_i = 7'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic       status_o;
  logic       line_done_o;
  logic       last_o;

  kbd_item_t   pending_items[$];
  result_t     expected_results[$];
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_max = 6;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  int unsigned in_gap_left = 0;

  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned out_wait = 0;
  int unsigned out_max = 6;
  int unsigned results_seen = 0;

  logic [7:0]  line_bytes [0:NL*LL-1];
  int unsigned line_len [NL];
  int unsigned line_off [NL];
  bit          line_rdy [NL];
  int unsigned wr_slot = 0;
  int unsigned wr_col = 0;
  int unsigned rd_slot = 0;

  line_edit_ring_buffer #(
    .NUM_LINES(NL),
    .LINE_LEN (LL),
    .MAX_READ (MR)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .key_char_i  (key_char_i),
    .read_len_i  (read_len_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_byte_o (data_byte_o),
    .byte_valid_o(byte_valid_o),
    .status_o    (status_o),
    .line_done_o (line_done_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic apply_keystroke(logic [7:0] ch);
    int unsigned ws;
    ws = wr_slot;
    if (line_rdy[ws]) return;
    line_off[ws] = 0;
    if (ch == KEY_NEWLINE) begin
      line_len[ws] = wr_col;
      line_rdy[ws] = 1'b1;
      wr_slot = (ws + 1) % NL;
      wr_col = 0;
    end else if (ch == KEY_BACKSPACE) begin
      if (wr_col > 0) wr_col--;
    end else if (wr_col < LL) begin
      line_bytes[ws*LL + wr_col] = ch;
      wr_col++;
    end
  endtask

  task automatic predict_line_read(logic [6:0] len);
    result_t     r;
    int unsigned rs;
    int unsigned want;
    int unsigned remain;
    int unsigned n;
    int unsigned col;
    bit          done;
    rs = rd_slot;
    r = '0;
    if (!line_rdy[rs]) begin
      r.status = 1'b1;
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    want = (len > MR) ? MR : len;
    remain = (line_len[rs] > line_off[rs]) ? line_len[rs] - line_off[rs] : 0;
    done = (remain <= want);
    n = done ? remain : want;
    if (n == 0) begin
      r.line_done = done;
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        col = line_off[rs] + i;
        r.data_byte = (col < LL) ? line_bytes[rs*LL + col] : 8'd0;
        r.byte_valid = 1'b1;
        r.status = 1'b0;
        r.line_done = done;
        r.last = (i + 1 == n);
        expected_results.push_back(r);
      end
    end
    if (done) begin
      line_len[rs] = 0;
      line_rdy[rs] = 1'b0;
      line_off[rs] = 0;
      rd_slot = (rs + 1) % NL;
    end else begin
      line_off[rs] = line_off[rs] + n;
    end
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic push_item(logic req, logic [7:0] ch, logic [6:0] len);
    kbd_item_t it;
    it.req = req;
    it.ch = ch;
    it.len = len;
    it.gap = $urandom_range(0, gap_max);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_key(logic [7:0] ch);
    push_item(REQ_KEY, ch, 7'($urandom_range(0, 127)));
  endtask

  task automatic push_read(logic [6:0] len);
    push_item(REQ_READ, 8'($urandom_range(0, 255)), len);
  endtask

  task automatic push_line(int unsigned n);
    logic [7:0] ch;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        ch = KEY_BACKSPACE;
      end else begin
        ch = 8'($urandom_range(0, 255));
        if (ch == KEY_NEWLINE) ch = 8'h20;
      end
      push_key(ch);
    end
    push_key(KEY_NEWLINE);
  endtask

  function automatic logic [6:0] pick_read_len();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'($urandom_range(65, 127));
      2: return 7'($urandom_range(21, 64));
      default: return 7'($urandom_range(1, 20));
    endcase
  endfunction

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    kbd_item_t cur;
    if (!in_valid_i || in_taken) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur = pending_items.pop_front();
        req_type_i <= cur.req;
        key_char_i <= cur.ch;
        read_len_i <= cur.len;
        in_valid_i <= 1'b1;
        in_gap_left = cur.gap;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (out_taken) begin
      out_wait = $urandom_range(0, out_max);
      results_seen++;
      if (results_seen % 40 == 0) out_max = ($urandom_range(0, 1) == 0) ? 0 : 6;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (out_wait > 0) begin
      out_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    out_taken = rst_ni && out_valid_o && !out_stall_i;
    if (in_taken) begin
      items_accepted++;
      if (req_type_i == REQ_READ) predict_line_read(read_len_i);
      else apply_keystroke(key_char_i);
    end
    if (out_taken) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no transaction pending, data_byte", data_byte_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (data_byte_o !== want.data_byte)
          report_mismatch("data_byte", data_byte_o, want.data_byte);
        if (byte_valid_o !== want.byte_valid)
          report_mismatch("byte_valid", byte_valid_o, want.byte_valid);
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (line_done_o !== want.line_done)
          report_mismatch("line_done", line_done_o, want.line_done);
        if (last_o !== want.last)
          report_mismatch("last", last_o, want.last);
      end
    end
    if (in_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned start_count;
    for (int unsigned s = 0; s < NL; s++) begin
      line_len[s] = 0;
      line_off[s] = 0;
      line_rdy[s] = 1'b0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    push_read(7'd5);
    push_key(8'h41);
    push_key(8'hFF);
    push_key(8'h00);
    push_key(KEY_BACKSPACE);
    push_key(8'h80);
    push_key(KEY_NEWLINE);
    push_key(KEY_BACKSPACE);
    push_key(KEY_NEWLINE);
    push_read(7'd0);
    push_read(7'd1);
    push_read(7'd127);
    push_read(7'd64);
    push_read(7'd1);
    repeat (NL) push_key(KEY_NEWLINE);
    push_key(8'h5A);
    push_key(KEY_NEWLINE);
    push_read(7'd64);
    wait_drained();

    gap_max = 0;
    for (int unsigned i = 0; i < LL + 2; i++) push_key(8'($urandom_range(11, 255)));
    push_key(KEY_NEWLINE);
    for (int unsigned i = 0; i < NL + 1; i++) push_read(7'd64);
    push_read(7'd127);
    hold_req = 1'b1;
    wait_drained();

    start_count = items_queued;
    while (items_queued - start_count < RANDOM_ITEMS) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: push_line($urandom_range(0, 12));
        5, 6, 7: repeat ($urandom_range(1, 3)) push_read(pick_read_len());
        8: repeat ($urandom_range(1, 3))
             push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       7'($urandom_range(0, 127)));
        default: repeat (NL) push_line($urandom_range(0, 3));
      endcase
    end
    wait_drained();
    repeat (16) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* line_edit_ring_buffer.f */
+incdir+design
design/ler_pkg.sv
design/ler_ram.sv
design/ler_out_fifo.sv
design/line_edit_ring_buffer.sv
dv/tb_line_edit_ring_buffer.sv
